@@ rtl/unicycle_motion_step_assert.svh @@
// Assertion macros used by the checker file.
`ifndef UNICYCLE_MOTION_STEP_ASSERT_SVH
`define UNICYCLE_MOTION_STEP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UCM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ucm check failed");

// Consequent must hold in the cycle after the antecedent.
`define UCM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ucm check failed");

`endif

@@ rtl/ucm_pkg.sv @@
`default_nettype none

package ucm_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND,
        S_TIME,
        S_CORD,
        S_REL,
        S_SSL,
        S_TSL,
        S_PC,
        S_PX,
        S_PS,
        S_PY,
        S_HD,
        S_FIN
    } ucm_state_t;

    // Result status codes.
    localparam logic [1:0] STATUS_STEP    = 2'd0;
    localparam logic [1:0] STATUS_QUEUED  = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPEED_SLEW = 2'd0;
    localparam logic [1:0] CFG_TURN_SLEW  = 2'd1;
    localparam logic [1:0] CFG_SPEED_DLY  = 2'd2;
    localparam logic [1:0] CFG_TURN_DLY   = 2'd3;

    // Input command codes.
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // Angle constants.
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [18:0] HALF_PI_H   = 19'sd12868;
    localparam logic signed [18:0] PI_H        = 19'sd25736;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

    // Queue status seen by the sequencer.
    typedef struct packed {
        logic full;
        logic empty;
    } ucm_q_stat_t;

    // Arctangent table for the rotation steps, Q2.30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // Move toward the goal by d and stop on the goal.
    function automatic logic signed [15:0] slew_step(input logic signed [15:0] now,
                                                     input logic signed [15:0] goal,
                                                     input logic [15:0] d);
        logic signed [17:0] n;
        logic signed [17:0] g;
        g = 18'(goal);
        if (goal >= now)
        begin
            n = 18'(now) + $signed({2'b00, d});
            if (n > g)
                n = g;
        end
        else
        begin
            n = 18'(now) - $signed({2'b00, d});
            if (n < g)
                n = g;
        end
        return n[15:0];
    endfunction

    // Add a heading increment, fold by pi once, saturate.
    function automatic logic signed [15:0] heading_add(input logic signed [15:0] h0,
                                                       input logic signed [17:0] inc);
        logic signed [18:0] h;
        h = 19'(h0) + 19'(inc);
        if (h > HALF_PI_H)
            h = h - PI_H;
        if (h < -HALF_PI_H)
            h = h + PI_H;
        if (h > 19'sd32767)
            h = 19'sd32767;
        if (h < -19'sd32768)
            h = -19'sd32768;
        return h[15:0];
    endfunction

    // Saturating signed position update.
    function automatic logic signed [31:0] pos_add(input logic signed [31:0] p,
                                                   input logic signed [27:0] inc);
        logic signed [32:0] s;
        s = 33'(p) + 33'(inc);
        if (s > 33'sd2147483647)
            s = 33'sd2147483647;
        if (s < -33'sd2147483648)
            s = -33'sd2147483648;
        return s[31:0];
    endfunction

    // Saturating unsigned time add.
    function automatic logic [31:0] time_add(input logic [31:0] t, input logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, t} + {1'b0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ucm_if.sv @@
`default_nettype none

// Input item channel.
interface ucm_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [15:0]        delta_t;
    logic signed [15:0] target_speed;
    logic signed [15:0] target_turn;

    modport source (output valid, command, delta_t, target_speed, target_turn,
                    input ready);
    modport sink (input valid, command, delta_t, target_speed, target_turn,
                  output ready);
endinterface

// Result item channel.
interface ucm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading_out;
    logic signed [15:0] speed_out;
    logic signed [15:0] turn_out;
    logic [31:0]        time_out;

    modport source (output valid, status, pos_x, pos_y, heading_out, speed_out,
                    turn_out, time_out, input ready);
    modport sink (input valid, status, pos_x, pos_y, heading_out, speed_out,
                  turn_out, time_out, output ready);
endinterface

// Configuration write channel.
interface ucm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [23:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

@@ rtl/unicycle_motion_step.sv @@
// Channel  | Role  | Beat contents
// in_ch    | sink  | command, delta_t, target_speed, target_turn
// out_ch   | src   | status, pos_x, pos_y, heading_out, speed_out, turn_out, time_out
// cfg_ch   | sink  | reg_index, wr_data (always ready)
//
// A step item goes from accept to result through the S_TIME time update, the S_CORD
// rotation steps on the shared shift/add unit, S_REL to S_HD through the one shared
// multiplier, and S_FIN, which loads the output register once it is free. A send
// item goes through S_SEND and S_FIN. Reset clears control, config and motion state.
// One item is in flight at a time; in_ch.ready is high only while idle.
// A result waits in the output register until taken.
`default_nettype none

module unicycle_motion_step #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ucm_in_if.sink    in_ch,
    ucm_out_if.source out_ch,
    ucm_cfg_if.sink   cfg_ch
);
    import ucm_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    ucm_state_t state_reg, state_next;

    logic               cmd_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] tspd_reg;
    logic signed [15:0] tturn_reg;

    logic [15:0]        speed_rate_reg;
    logic [15:0]        turn_rate_reg;
    logic [23:0]        speed_dly_reg;
    logic [23:0]        turn_dly_reg;

    logic [31:0]        time_reg;
    logic signed [31:0] posx_reg;
    logic signed [31:0] posy_reg;
    logic signed [15:0] heading_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] speed_goal_reg;
    logic signed [15:0] turn_reg;
    logic signed [15:0] turn_goal_reg;

    logic signed [35:0] cx_reg;
    logic signed [35:0] cy_reg;
    logic signed [35:0] cz_reg;
    logic               neg_reg;
    logic [IW-1:0]      iter_reg;

    logic [1:0]         status_reg;
    logic               out_valid_reg;
    logic               load_out;

    logic               sq_push, tq_push, sq_pop, tq_pop;
    ucm_q_stat_t        sq_stat, tq_stat;
    logic [31:0]        sq_due, tq_due;
    logic signed [15:0] sq_val, tq_val;
    logic               any_full;

    logic signed [47:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [65:0] mul_p;

    logic signed [35:0] c_val, s_val;
    logic signed [35:0] sx, sy, at;
    logic signed [35:0] z0;
    logic signed [17:0] dt_s;

    assign any_full = sq_stat.full || tq_stat.full;
    assign dt_s     = $signed({2'b00, dt_reg});

    // Command queues.
    ucm_queue #(.DEPTH(QUEUE_DEPTH)) u_speed_q (
        .clk(clk), .rst_n(rst_n), .push(sq_push),
        .push_due(time_add(time_reg, {8'h00, speed_dly_reg})), .push_val(tspd_reg),
        .pop(sq_pop), .stat(sq_stat), .head_due(sq_due), .head_val(sq_val)
    );

    ucm_queue #(.DEPTH(QUEUE_DEPTH)) u_turn_q (
        .clk(clk), .rst_n(rst_n), .push(tq_push),
        .push_due(time_add(time_reg, {8'h00, turn_dly_reg})), .push_val(tturn_reg),
        .pop(tq_pop), .stat(tq_stat), .head_due(tq_due), .head_val(tq_val)
    );

    // Shared multiplier.
    ucm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    // Rotation step terms and folded start angle.
    assign c_val = neg_reg ? -cx_reg : cx_reg;
    assign s_val = neg_reg ? -cy_reg : cy_reg;
    assign sx    = cx_reg >>> iter_reg;
    assign sy    = cy_reg >>> iter_reg;
    assign at    = $signed({6'b0, atan_q30(5'(iter_reg))});
    assign z0    = $signed({{3{heading_reg[15]}}, heading_reg, 17'b0});

    // Next state, output load and queue push/pop controls.
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        sq_push    = 1'b0;
        tq_push    = 1'b0;
        sq_pop     = 1'b0;
        tq_pop     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                    state_next = (in_ch.command == CMD_SEND) ? S_SEND : S_TIME;
            end
            S_SEND:
            begin
                sq_push    = !any_full;
                tq_push    = !any_full;
                state_next = S_FIN;
            end
            S_TIME: state_next = S_CORD;
            S_CORD:
            begin
                if (iter_reg == IW'(CORDIC_STEPS - 1))
                    state_next = S_REL;
            end
            S_REL:
            begin
                sq_pop     = !sq_stat.empty && (sq_due <= time_reg);
                tq_pop     = !tq_stat.empty && (tq_due <= time_reg);
                state_next = S_SSL;
            end
            S_SSL: state_next = S_TSL;
            S_TSL: state_next = S_PC;
            S_PC:  state_next = S_PX;
            S_PX:  state_next = S_PS;
            S_PS:  state_next = S_PY;
            S_PY:  state_next = S_HD;
            S_HD:  state_next = S_FIN;
            S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_REL:
            begin
                mul_a = $signed({32'b0, speed_rate_reg});
                mul_b = dt_s;
            end
            S_SSL:
            begin
                mul_a = $signed({32'b0, turn_rate_reg});
                mul_b = dt_s;
            end
            S_TSL:
            begin
                mul_a = 48'(c_val);
                mul_b = 18'(speed_reg);
            end
            S_PC, S_PS:
            begin
                mul_a = mul_p[47:0];
                mul_b = dt_s;
            end
            S_PX:
            begin
                mul_a = 48'(s_val);
                mul_b = 18'(speed_reg);
            end
            S_PY:
            begin
                mul_a = 48'(turn_reg);
                mul_b = dt_s;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Input item capture.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            cmd_reg   <= in_ch.command;
            dt_reg    <= in_ch.delta_t;
            tspd_reg  <= in_ch.target_speed;
            tturn_reg <= in_ch.target_turn;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_rate_reg <= 16'd256;
            turn_rate_reg  <= 16'd4096;
            speed_dly_reg  <= '0;
            turn_dly_reg   <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.reg_index)
                CFG_SPEED_SLEW: speed_rate_reg <= cfg_ch.wr_data[15:0];
                CFG_TURN_SLEW:  turn_rate_reg  <= cfg_ch.wr_data[15:0];
                CFG_SPEED_DLY:  speed_dly_reg  <= cfg_ch.wr_data;
                CFG_TURN_DLY:   turn_dly_reg   <= cfg_ch.wr_data;
                default:        speed_dly_reg  <= speed_dly_reg;
            endcase
        end
    end

    // Motion state, updated step by step by the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            posx_reg       <= '0;
            posy_reg       <= '0;
            heading_reg    <= '0;
            speed_reg      <= '0;
            speed_goal_reg <= '0;
            turn_reg       <= '0;
            turn_goal_reg  <= '0;
            status_reg     <= STATUS_STEP;
        end
        else
        begin
            unique case (state_reg)
                S_SEND: status_reg <= any_full ? STATUS_DROPPED : STATUS_QUEUED;
                S_TIME:
                begin
                    time_reg   <= time_add(time_reg, {16'h0000, dt_reg});
                    status_reg <= STATUS_STEP;
                end
                S_REL:
                begin
                    if (sq_pop)
                        speed_goal_reg <= sq_val;
                    if (tq_pop)
                        turn_goal_reg <= tq_val;
                end
                S_SSL: speed_reg <= slew_step(speed_reg, speed_goal_reg, mul_p[31:16]);
                S_TSL: turn_reg  <= slew_step(turn_reg, turn_goal_reg, mul_p[31:16]);
                S_PX:  posx_reg  <= pos_add(posx_reg, mul_p[65:38]);
                S_PY:  posy_reg  <= pos_add(posy_reg, mul_p[65:38]);
                S_HD:  heading_reg <= heading_add(heading_reg, mul_p[32:15]);
                default: status_reg <= status_reg;
            endcase
        end
    end

    // Sine/cosine rotation unit.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TIME)
        begin
            cx_reg   <= GAIN_Q30;
            cy_reg   <= '0;
            iter_reg <= '0;
            if (heading_reg >= HALF_PI_Q13)
            begin
                cz_reg  <= z0 - PI_Q30;
                neg_reg <= 1'b1;
            end
            else if (heading_reg <= -HALF_PI_Q13)
            begin
                cz_reg  <= z0 + PI_Q30;
                neg_reg <= 1'b1;
            end
            else
            begin
                cz_reg  <= z0;
                neg_reg <= 1'b0;
            end
        end
        else if (state_reg == S_CORD)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (!cz_reg[35])
            begin
                cx_reg <= cx_reg - sy;
                cy_reg <= cy_reg + sx;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + sy;
                cy_reg <= cy_reg - sx;
                cz_reg <= cz_reg + at;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_ch.status      <= (cmd_reg == CMD_SEND) ? status_reg : STATUS_STEP;
            out_ch.pos_x       <= posx_reg;
            out_ch.pos_y       <= posy_reg;
            out_ch.heading_out <= heading_reg;
            out_ch.speed_out   <= speed_reg;
            out_ch.turn_out    <= turn_reg;
            out_ch.time_out    <= time_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;

endmodule

`default_nettype wire

@@ rtl/ucm_queue.sv @@
`default_nettype none

module ucm_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [31:0]          push_due,
    input  wire logic signed [15:0]   push_val,
    input  wire logic                 pop,
    output ucm_pkg::ucm_q_stat_t      stat,
    output logic [31:0]               head_due,
    output logic signed [15:0]        head_val
);
    import ucm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [47:0]   mem [DEPTH];
    logic [47:0]   rd_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [CW-1:0] count_reg;

    // Entry storage with a registered read at the head.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[tail_reg] <= {push_due, push_val};
        rd_reg <= mem[head_reg];
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            if (pop)
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_due   = rd_reg[47:16];
    assign head_val   = rd_reg[15:0];

endmodule

`default_nettype wire

@@ rtl/ucm_mul.sv @@
`default_nettype none

module ucm_mul (
    input  wire logic                clk,
    input  wire logic signed [47:0]  a,
    input  wire logic signed [17:0]  b,
    output logic signed [65:0]       p
);
    import ucm_pkg::*;

    logic signed [65:0] p_reg;

    // Shared signed multiplier with a registered product.
    always_ff @(posedge clk)
    begin
        p_reg <= 66'(a) * 66'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

@@ rtl/ucm_checker.sv @@
`default_nettype none
`include "unicycle_motion_step_assert.svh"

module ucm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_status
);
    import ucm_pkg::*;

    // A waiting result stays offered until taken.
    `UCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // The block is busy on the cycle after it takes an item.
    `UCM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // Only defined status codes are reported.
    `UCM_ASSERT_SAME(a_status_code, out_valid,
        out_status == STATUS_STEP || out_status == STATUS_QUEUED || out_status == STATUS_DROPPED)

endmodule

bind unicycle_motion_step ucm_checker u_ucm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_status(out_ch.status)
);

`default_nettype wire
